/* sv/red_pkg.sv */
// Shared constants, codes and beat types for the RED admission queue.
package red_pkg;

	localparam int DEPTH    = 64;
	localparam int DATA_W   = 32;
	localparam int AVG_FRAC = 8;
	localparam int PTR_W    = $clog2(DEPTH);
	localparam int CNT_W    = 7;
	localparam int THR_W    = 7;
	localparam int AVG_W    = 15;
	localparam int DRAW_W   = 16;
	localparam int ST_W     = 3;
	localparam int CFG_W    = 32;
	localparam int ADDR_W   = 3;

	typedef logic [ST_W-1:0] status_t;

	localparam status_t ST_ACCEPT   = 3'd0;
	localparam status_t ST_RANDOM   = 3'd1;
	localparam status_t ST_OVERMAX  = 3'd2;
	localparam status_t ST_FULL     = 3'd3;
	localparam status_t ST_DEQUEUED = 3'd4;
	localparam status_t ST_EMPTY    = 3'd5;

	localparam logic OP_OFFER = 1'b0;
	localparam logic OP_TAKE  = 1'b1;

	localparam logic REG_MIN = 1'b0;
	localparam logic REG_MAX = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [DATA_W-1:0] item_data;
		logic [DRAW_W-1:0] random_draw;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] out_data;
		logic [CNT_W-1:0]  fill_count;
		logic [AVG_W-1:0]  average_fill;
	} rsp_t;

	typedef struct packed {
		logic [THR_W-1:0] min_thr;
		logic [THR_W-1:0] max_thr;
	} thr_cfg_t;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [DATA_W-1:0] wdata;
	} ring_req_t;

endpackage

/* sv/red_cfg.sv */
// APB threshold registers.
module red_cfg
	import red_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]  pwdata,
	output logic [CFG_W-1:0]  prdata,
	output logic              pready,
	output thr_cfg_t          cfg
);

	logic [THR_W-1:0] min_q;
	logic [THR_W-1:0] max_q;
	logic             wr_en;
	logic             sel;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign sel    = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= THR_W'(16);
			max_q <= THR_W'(48);
		end else if (wr_en) begin
			unique case (sel)
				REG_MIN: min_q <= pwdata[THR_W-1:0];
				REG_MAX: max_q <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_MIN: prdata = CFG_W'(min_q);
			REG_MAX: prdata = CFG_W'(max_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.min_thr = min_q;
	assign cfg.max_thr = max_q;

endmodule

/* sv/red_ring.sv */
// Ring buffer storage with wrapping pointers and registered read.
module red_ring
	import red_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ring_req_t         ring,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [DATA_W-1:0] rd_data_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (ring.push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (ring.pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ring.push)
			mem[wr_ptr_q] <= ring.wdata;
		if (ring.pop)
			rd_data_q <= mem[rd_ptr_q];
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/red_ctrl.sv */
// Input register, RED admission decision, fill/average state and result register.
module red_ctrl
	import red_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output status_t          rsp_status,
	output logic [CNT_W-1:0] rsp_fill,
	output logic [AVG_W-1:0] rsp_avg,
	input  thr_cfg_t         cfg,
	output ring_req_t        ring
);

	localparam int LHS_W = DRAW_W + THR_W + AVG_FRAC;
	localparam int RHS_W = AVG_W + DRAW_W;

	req_t             req_s1;
	logic             valid_s1;
	logic             advance;
	logic             rsp_valid_q;
	status_t          status_q;
	logic [CNT_W-1:0] fill_q;
	logic [AVG_W-1:0] avg_rsp_q;

	logic [CNT_W-1:0] count_q;
	logic [AVG_W-1:0] avg_q;

	logic [AVG_W-1:0]        min_fx;
	logic [AVG_W-1:0]        max_fx;
	logic [THR_W-1:0]        span;
	logic [DRAW_W+THR_W-1:0] prod;
	logic [LHS_W-1:0]        lhs;
	logic [RHS_W-1:0]        rhs;
	logic [CNT_W-1:0]        count_inc;
	logic [AVG_W-1:0]        avg_once;
	logic [AVG_W-1:0]        avg_acc1;
	logic [AVG_W-1:0]        avg_acc2;

	status_t          status_d;
	logic [CNT_W-1:0] count_d;
	logic [AVG_W-1:0] avg_d;
	logic             push_d;
	logic             pop_d;

	function automatic logic [AVG_W-1:0] avg_upd(input logic [AVG_W-1:0] a,
		input logic [CNT_W-1:0] c);
		logic [AVG_W:0] sum;
		sum = {1'b0, a} + ((AVG_W + 1)'(c) << AVG_FRAC);
		avg_upd = sum[AVG_W:1];
	endfunction

	assign advance   = valid_s1 & (~rsp_valid_q | ~rsp_stall);
	assign req_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req_valid && !req_stall)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			req_s1 <= req;
	end

	assign min_fx    = AVG_W'(cfg.min_thr) << AVG_FRAC;
	assign max_fx    = AVG_W'(cfg.max_thr) << AVG_FRAC;
	assign span      = (cfg.max_thr > cfg.min_thr) ? cfg.max_thr - cfg.min_thr : '0;
	assign prod      = (DRAW_W + THR_W)'(req_s1.random_draw) * (DRAW_W + THR_W)'(span);
	assign lhs       = LHS_W'(prod) << AVG_FRAC;
	assign rhs       = RHS_W'(avg_q - min_fx) << DRAW_W;
	assign count_inc = count_q + CNT_W'(1);
	assign avg_once  = avg_upd(avg_q, count_q);
	assign avg_acc1  = avg_upd(avg_q, count_inc);
	assign avg_acc2  = avg_upd(avg_acc1, count_inc);

	always_comb begin
		status_d = ST_EMPTY;
		count_d  = count_q;
		avg_d    = avg_q;
		push_d   = 1'b0;
		pop_d    = 1'b0;
		if (req_s1.opcode == OP_OFFER) begin
			if (avg_q > max_fx) begin
				status_d = ST_OVERMAX;
				avg_d    = avg_once;
			end else if (avg_q > min_fx && lhs < rhs) begin
				status_d = ST_RANDOM;
				avg_d    = avg_once;
			end else if (count_q >= CNT_W'(DEPTH)) begin
				status_d = ST_FULL;
				avg_d    = avg_once;
			end else begin
				status_d = ST_ACCEPT;
				count_d  = count_inc;
				avg_d    = avg_acc2;
				push_d   = 1'b1;
			end
		end else if (count_q != '0) begin
			status_d = ST_DEQUEUED;
			count_d  = count_q - CNT_W'(1);
			pop_d    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			avg_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			count_q     <= count_d;
			avg_q       <= avg_d;
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q  <= status_d;
			fill_q    <= count_d;
			avg_rsp_q <= avg_d;
		end
	end

	assign ring.push  = advance & push_d;
	assign ring.pop   = advance & pop_d;
	assign ring.wdata = req_s1.item_data;

	assign rsp_valid  = rsp_valid_q;
	assign rsp_status = status_q;
	assign rsp_fill   = fill_q;
	assign rsp_avg    = avg_rsp_q;

endmodule

/* sv/red_queue_admission.sv */
// Top level of the RED admission queue.
//
//  channel  direction  handshake          beat
//  req      in         req_valid/stall    opcode, item_data, random_draw
//  rsp      out        rsp_valid/stall    status, out_data, fill_count, average_fill
//  apb      in/out     psel/penable       min_threshold @0x0, max_threshold @0x4
//
// One beat per cycle sustained while rsp is not stalled; a request reaches rsp through
// the input register, then the decision into the result register and ring read port.
// Reset clears fill count, average, pointers and both valids; thresholds go to 16/48.
// A stalled rsp holds the result; one more request waits in the input register,
// after which req_stall rises.
module red_queue_admission
	import red_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]  pwdata,
	output logic [CFG_W-1:0]  prdata,
	output logic              pready
);

	thr_cfg_t          cfg;
	ring_req_t         ring;
	logic [DATA_W-1:0] rd_data;
	status_t           rsp_status;
	logic [CNT_W-1:0]  rsp_fill;
	logic [AVG_W-1:0]  rsp_avg;

	red_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	red_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_status (rsp_status),
		.rsp_fill   (rsp_fill),
		.rsp_avg    (rsp_avg),
		.cfg        (cfg),
		.ring       (ring)
	);

	red_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ring    (ring),
		.rd_data (rd_data)
	);

	assign rsp.status       = rsp_status;
	assign rsp.out_data     = (rsp_status == ST_DEQUEUED) ? rd_data : '0;
	assign rsp.fill_count   = rsp_fill;
	assign rsp.average_fill = rsp_avg;

endmodule
